/* sv/bpct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_pkg
// Shared constants of the block/piece completion tracker.
// ----------------------------------------------------------------------------
package bpct_pkg;
  localparam int MAX_BLOCKS_DEF    = 65536;
  localparam int MAX_PIECES_DEF    = 4096;
  localparam int MAP_WORD_BITS_DEF = 64;
  localparam int TOT_W             = 37;
  localparam int CNT_W             = 11;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SKIP   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [1:0] CFG_BLOCK_LOG2  = 2'd1;
  localparam logic [1:0] CFG_PIECE_LOG2  = 2'd2;
  localparam logic [1:0] CFG_LAST_BYTES  = 2'd3;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_WANTED     = 2'd1;
  localparam logic [1:0] ST_ALL        = 2'd2;
endpackage

/* sv/bpct_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module bpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/block_piece_completion_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_piece_completion_tracker
// Block bitmap, per-piece counts/skip flags and running byte totals.
// Add, skip and no-op requests pass S_RD, S_CALC, S_RMW, S_UPD and S_OUT; a valid
// remove also passes S_WIPE, with one write per map word of the piece or a single
// masked write for pieces within one map word. One transaction at a time: the next
// input is taken once the result is loaded. Reset and every config write start a
// clearing pass over every map word and piece count; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module block_piece_completion_tracker
  import bpct_pkg::*;
#(
  parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int MAX_PIECES    = MAX_PIECES_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [20:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // req_type[1:0], item_index[17:2], skip_flag[18]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata    // index_error, block_was_present, piece_complete,
                                  // piece_missing_blocks[11], complete, done,
                                  // wanted, verified bytes[37 each], status[2]
);
  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WA_W      = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int PA_W      = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CLR_N     = (MAP_WORDS > MAX_PIECES) ? MAP_WORDS : MAX_PIECES;
  localparam int CLR_W     = $clog2(CLR_N + 1);
  localparam int BLK_W     = $clog2(MAX_BLOCKS + 1);
  localparam int PCNT_W    = $clog2(MAX_PIECES + 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RD    = 8'b00000100,
    S_CALC  = 8'b00001000,
    S_RMW   = 8'b00010000,
    S_WIPE  = 8'b00100000,
    S_UPD   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;

  // raw config
  logic [16:0] cfg_blocks;
  logic [4:0]  cfg_bbl;
  logic [3:0]  cfg_bpl;
  logic [20:0] cfg_last;

  // effective config
  logic [4:0]  e_bbl;
  logic [3:0]  e_bpl;
  logic [20:0] e_last;
  logic [BLK_W-1:0] e_blocks;
  logic [PCNT_W-1:0] e_pieces;
  logic [TOT_W-1:0] e_total;
  logic [TOT_W-1:0] e_bsz;

  always_comb begin
    logic [4:0]  b;
    logic [3:0]  p;
    logic [20:0] l;
    logic [20:0] bs;
    logic [BLK_W:0] n;
    logic [BLK_W+11:0] cap;
    b = (cfg_bbl < 5'd10) ? 5'd10 : ((cfg_bbl > 5'd20) ? 5'd20 : cfg_bbl);
    p = (cfg_bpl > 4'd10) ? 4'd10 : cfg_bpl;
    bs = 21'd1 << b;
    l = (cfg_last == 21'd0) ? 21'd1 : ((cfg_last > bs) ? bs : cfg_last);
    n = (BLK_W+1)'(cfg_blocks);
    if (n == '0) n = (BLK_W+1)'(1);
    if (n > (BLK_W+1)'(MAX_BLOCKS)) n = (BLK_W+1)'(MAX_BLOCKS);
    cap = (BLK_W+12)'(MAX_PIECES) << p;
    if ((BLK_W+12)'(n) > cap) n = (BLK_W+1)'(cap);
    e_bbl = b;
    e_bpl = p;
    e_last = l;
    e_blocks = BLK_W'(n);
    e_bsz = TOT_W'(bs);
  end

  // derived values registered (shift/adds kept off the request path)
  always_ff @(posedge clk) begin
    e_pieces <= PCNT_W'((({1'b0, e_blocks} + ((BLK_W+1)'(1) << e_bpl)) - (BLK_W+1)'(1))
                        >> e_bpl);
    e_total  <= (TOT_W'(e_blocks - BLK_W'(1)) << e_bbl) + TOT_W'(e_last);
  end

  // RAMs
  logic                     map_we;
  logic [WA_W-1:0]          map_addr;
  logic [MAP_WORD_BITS-1:0] map_wdata, map_rdata;
  logic                     pc_we;
  logic [PA_W-1:0]          pc_addr;
  logic [CNT_W:0]           pc_wdata, pc_rdata;  // {skip, count}

  bpct_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
  );
  bpct_ram #(.WIDTH(CNT_W+1), .DEPTH(MAX_PIECES)) u_piece (
    .clk(clk), .we(pc_we), .addr(pc_addr), .wdata(pc_wdata), .rdata(pc_rdata)
  );

  // request regs
  logic [1:0]  req;
  logic [15:0] idx;
  logic        flag;
  logic        err;
  logic [PCNT_W-1:0] piece;
  logic [CLR_W-1:0]  cnt;
  logic [WA_W:0]     wipe_n, wipe_i;
  logic              last_piece;
  logic [CNT_W-1:0]  need, need_c;
  logic [CNT_W-1:0]  got, got_c;
  logic              skip;
  logic              was, was_c;
  logic [TOT_W-1:0]  pbytes, tbytes, pbytes_c, tbytes_c;
  logic [TOT_W-1:0]  complete_total, done_total, wanted_total, verified_total;
  logic [1:0]        stat;
  logic              pc_o;
  logic [CNT_W-1:0]  miss_o;
  logic              was_o;
  logic              have_piece;

  logic [WA_W-1:0]  blk_word;
  logic [BIT_W-1:0] blk_bit;
  logic [BLK_W-1:0] idx_b;
  logic [BLK_W-1:0] last_b;
  assign idx_b    = BLK_W'(idx);
  assign last_b   = e_blocks - BLK_W'(1);
  assign blk_word = WA_W'(idx_b >> BIT_W);
  assign blk_bit  = BIT_W'(idx_b);
  assign have_piece = !err && (req != REQ_NONE);

  // first block of the piece
  logic [BLK_W+PCNT_W-1:0] pstart;
  assign pstart = (BLK_W+PCNT_W)'(piece) << e_bpl;

  assign s_tready = (state == S_IDLE);

  // partial-word clear for small pieces (piece smaller than a map word):
  // masked write in S_WIPE using the word read in S_RMW.
  logic [MAP_WORD_BITS-1:0] pmask;
  always_comb begin
    logic [MAP_WORD_BITS-1:0] ones;
    ones = (MAP_WORD_BITS'(1) << (MAP_WORD_BITS'(1) << e_bpl)) - MAP_WORD_BITS'(1);
    if (e_bpl >= 4'(BIT_W)) ones = '1;
    pmask = ones << BIT_W'(pstart);
  end

  logic sub_word;
  assign sub_word = (e_bpl < 4'(BIT_W));

  // piece geometry and byte amounts, valid in S_RMW
  always_comb begin
    last_piece = ({1'b0, piece} + (PCNT_W+1)'(1)) == {1'b0, e_pieces};
    need_c = last_piece ? CNT_W'(e_blocks - BLK_W'(pstart)) : (CNT_W'(1) << e_bpl);
    was_c = (req == REQ_ADD) && map_rdata[blk_bit];
    if (req == REQ_ADD) begin
      got_c = pc_rdata[CNT_W-1:0] + CNT_W'(!err && !map_rdata[blk_bit]);
      pbytes_c = (idx_b == last_b) ? TOT_W'(e_last) : e_bsz;
    end else begin
      got_c = pc_rdata[CNT_W-1:0];
      pbytes_c = TOT_W'(pc_rdata[CNT_W-1:0]) << e_bbl;
      if (last_piece && map_rdata[BIT_W'(last_b)])
        pbytes_c = (TOT_W'(pc_rdata[CNT_W-1:0]) << e_bbl) - e_bsz + TOT_W'(e_last);
    end
    tbytes_c = last_piece ?
      ((TOT_W'(need_c) << e_bbl) - e_bsz + TOT_W'(e_last)) :
      (TOT_W'(need_c) << e_bbl);
  end

  always_comb begin
    map_we = 1'b0;
    map_addr = blk_word;
    map_wdata = map_rdata | (MAP_WORD_BITS'(1) << blk_bit);
    pc_we = 1'b0;
    pc_addr = PA_W'(piece);
    pc_wdata = {skip, got};
    unique case (state)
      S_CLEAR: begin
        map_we = (cnt < CLR_W'(MAP_WORDS));
        map_addr = WA_W'(cnt);
        map_wdata = '0;
        pc_we = (cnt < CLR_W'(MAX_PIECES));
        pc_addr = PA_W'(cnt);
        pc_wdata = '0;
      end
      S_RD, S_CALC: begin
        if (req != REQ_ADD) map_addr = WA_W'(last_b >> BIT_W);
      end
      S_RMW: begin
        if (req == REQ_REMOVE) map_addr = WA_W'(pstart >> BIT_W);
        map_we = (req == REQ_ADD) && !err && !was_c;
      end
      S_WIPE: begin
        map_addr = WA_W'((pstart >> BIT_W) + (BLK_W+PCNT_W)'(wipe_i));
        // clear only bits inside the piece
        map_wdata = sub_word ? (map_rdata & ~pmask) : '0;
        map_we = 1'b1;
      end
      S_UPD: begin
        pc_we = have_piece;
        pc_wdata = {((req == REQ_SKIP) ? flag : skip),
                    ((req == REQ_REMOVE) ? CNT_W'(0) : got)};
      end
      default: ;
    endcase
  end

  logic [TOT_W-1:0] ct_n, dt_n, wt_n, vt_n;

  always_comb begin
    logic [CNT_W-1:0] g;
    g = got;
    ct_n = complete_total;
    dt_n = done_total;
    wt_n = wanted_total;
    vt_n = verified_total;
    if (!err) begin
      unique case (req)
        REQ_ADD: begin
          if (!was) begin
            ct_n = complete_total + pbytes;
            if (!skip) dt_n = done_total + pbytes;
            if (g == need) vt_n = verified_total + tbytes;
          end
        end
        REQ_REMOVE: begin
          ct_n = complete_total - pbytes;
          if (!skip) dt_n = done_total - pbytes;
          if (g == need) vt_n = verified_total - tbytes;
        end
        REQ_SKIP: begin
          if (skip != flag) begin
            if (flag) begin
              dt_n = done_total - pbytes;
              wt_n = wanted_total - tbytes;
            end else begin
              dt_n = done_total + pbytes;
              wt_n = wanted_total + tbytes;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      m_tvalid <= 1'b0;
      cfg_blocks <= 17'd1;
      cfg_bbl <= 5'd14;
      cfg_bpl <= 4'd4;
      cfg_last <= 21'd16384;
      complete_total <= '0;
      done_total <= '0;
      verified_total <= '0;
      wanted_total <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_COUNT: cfg_blocks <= cfg_data[16:0];
          CFG_BLOCK_LOG2:  cfg_bbl <= cfg_data[4:0];
          CFG_PIECE_LOG2:  cfg_bpl <= cfg_data[3:0];
          CFG_LAST_BYTES:  cfg_last <= cfg_data;
          default: ;
        endcase
        state <= S_CLEAR;
        cnt <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            cnt <= cnt + CLR_W'(1);
            complete_total <= '0;
            done_total <= '0;
            verified_total <= '0;
            wanted_total <= e_total;
            if (cnt == CLR_W'(CLR_N)) state <= S_IDLE;
          end
          S_IDLE: begin
            if (s_tvalid) begin
              req <= s_tdata[1:0];
              idx <= s_tdata[17:2];
              flag <= s_tdata[18];
              state <= S_RD;
            end
          end
          S_RD: begin
            // idx holds block index for add; piece index otherwise
            if (req == REQ_ADD) begin
              err <= (32'(idx) >= 32'(e_blocks));
              piece <= PCNT_W'(idx_b >> e_bpl);
            end else begin
              err <= (req != REQ_NONE) && (32'(idx) >= 32'(e_pieces));
              piece <= PCNT_W'(idx);
            end
            state <= S_CALC;
          end
          S_CALC: begin
            // piece RAM address now valid; map word read issued again
            state <= S_RMW;
          end
          S_RMW: begin
            // pc_rdata and map_rdata valid here
            need <= need_c;
            skip <= pc_rdata[CNT_W];
            was <= was_c;
            got <= got_c;
            pbytes <= pbytes_c;
            tbytes <= tbytes_c;
            wipe_i <= '0;
            wipe_n <= sub_word ? (WA_W+1)'(1) :
                      (WA_W+1)'((BLK_W+PCNT_W)'(need_c + CNT_W'(MAP_WORD_BITS - 1)) >> BIT_W);
            state <= S_UPD;
            if (req == REQ_REMOVE && !err) state <= S_WIPE;
          end
          S_WIPE: begin
            // sub-word pieces: one masked write of the word read back
            if (sub_word) begin
              state <= S_UPD;
            end else begin
              wipe_i <= wipe_i + (WA_W+1)'(1);
              if (wipe_i + (WA_W+1)'(1) == wipe_n) state <= S_UPD;
            end
          end
          S_UPD: begin
            complete_total <= ct_n;
            done_total <= dt_n;
            wanted_total <= wt_n;
            verified_total <= vt_n;
            if (req == REQ_REMOVE && !err) got <= '0;
            state <= S_OUT;
          end
          S_OUT: begin
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              was_o <= !err && (req == REQ_ADD) && was;
              pc_o <= have_piece && (got >= need);
              miss_o <= (!have_piece || got >= need) ? '0 : need - got;
              state <= S_IDLE;
            end
          end
          default: state <= S_CLEAR;
        endcase
      end
    end
  end

  // status from the latest totals
  always_comb begin
    if (complete_total == e_total) stat = ST_ALL;
    else if (done_total >= wanted_total) stat = ST_WANTED;
    else stat = ST_INCOMPLETE;
  end

  logic err_o;
  logic [TOT_W-1:0] ct_o, dt_o, wt_o, vt_o;
  logic [1:0] st_o;
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      err_o <= err;
      ct_o <= complete_total;
      dt_o <= done_total;
      wt_o <= wanted_total;
      vt_o <= verified_total;
      st_o <= stat;
    end
  end

  assign m_tdata = {4'b0000, st_o, vt_o, wt_o, dt_o, ct_o, miss_o, pc_o, was_o, err_o};
endmodule
